/* sv/tse_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and reset values for the timestamp wrap extender
package tse_pkg;

    localparam int unsigned OP_W      = 2;
    localparam int unsigned CFG_IDX_W = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_TIMER   = 2'd0;
    localparam logic [OP_W-1:0] OP_EVENT   = 2'd1;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_MASK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_OFFSET   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_FACTOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SANITY_WINDOW = 3'd4;

    // reset values
    localparam logic [63:0] WRAP_MASK_RST     = 64'h0000_0000_FFFF_FFFF;
    localparam logic [62:0] WRAP_STEP_RST     = 63'h0000_0001_0000_0000;
    localparam logic [31:0] SANITY_WINDOW_RST = 32'd5000000;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [63:0]        raw_time;
        logic signed [63:0] device_time;
        logic               device_time_ok;
    } sample_t;

    typedef struct packed {
        logic signed [63:0] time_out;
        logic               wrapped;
        logic               forced_forward;
        logic               clamped;
        logic               device_time_missing;
    } result_t;

    typedef struct packed {
        logic [63:0] wrap_mask;
        logic [62:0] wrap_step;
        logic [31:0] sanity_window;
    } cfg_t;

    // input register contents: masked low value and device gap without high part
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [63:0]     low;
        logic [63:0]     dev_gap;
        logic            dev_ok;
    } stage0_t;

    // item as it travels down the correction pipeline
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [63:0]     value;
        logic            wrapped;
        logic            forced_forward;
        logic            device_time_missing;
    } pipe_t;

endpackage

/* sv/timestamp_wrap_extender.sv */
`timescale 1ns / 1ps
// top level of the timestamp wrap extender: config registers and correction pipeline
//
// usage
//   sample channel (sample_valid / sample_stall / sample) takes one operation per
//   transaction: timer sample, event timestamp, timeout catch-up or clear
//   result channel (result_valid / result_stall / result) returns exactly one
//   transaction per sample, in order
//   throughput: one transaction per cycle while the result is not stalled;
//   wrap tracking closes in the stage after the input register, drift is a
//   64x48 multiply split into four partial products over three stages, the
//   monotonic clamp sits at the result register
//   config port (cfg_we / cfg_index / cfg_data) writes one register per edge
//   and ignores unknown indexes; the user must write only while no transaction
//   is in flight, the block does not enforce it; reset: all tracking state cleared,
//   registers to their defaults, pipe empty; a stalled result holds; stages behind
//   it keep filling bubbles and then sample_stall rises
module timestamp_wrap_extender
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  tse_pkg::sample_t                sample,
    output logic                            result_valid,
    input  logic                            result_stall,
    output tse_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [tse_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [63:0]                     cfg_data
);

    // configuration
    logic [63:0] wrap_mask_reg;
    logic [62:0] wrap_step_reg;
    logic [63:0] sync_offset_reg;
    logic        drift_neg_reg;
    logic [47:0] drift_mag_reg;
    logic [31:0] sanity_window_reg;
    tse_pkg::cfg_t cfg;

    // handshake
    logic [7:0] valid_reg;
    logic       result_valid_reg;
    logic [8:0] ready;
    logic       track_fire;

    // stage payloads
    tse_pkg::stage0_t s0_reg;
    tse_pkg::stage0_t s0_next;
    tse_pkg::pipe_t   track_out;
    tse_pkg::pipe_t   p1_reg;
    logic [63:0]      o1_reg;
    tse_pkg::pipe_t   p2_reg;
    tse_pkg::pipe_t   p2_next;
    tse_pkg::pipe_t   p3_reg;
    logic [63:0]      mag3_reg;
    logic [63:0]      mag3_next;
    logic             neg3_reg;
    tse_pkg::pipe_t   p4_reg;
    logic [63:0]      pp00_reg;
    logic [47:0]      pp01_reg;
    logic [63:0]      pp10_reg;
    logic [47:0]      pp11_reg;
    logic [63:0]      pp00_next;
    logic [47:0]      pp01_next;
    logic [63:0]      pp10_next;
    logic [47:0]      pp11_next;
    logic             neg4_reg;
    tse_pkg::pipe_t   p5_reg;
    logic [111:0]     low5_reg;
    logic [64:0]      mid5_reg;
    logic             neg5_reg;
    tse_pkg::pipe_t   p6_reg;
    logic [103:0]     sum6;
    logic [63:0]      m6_reg;
    logic             neg6_reg;
    tse_pkg::pipe_t   p7_reg;
    tse_pkg::pipe_t   p7_next;
    tse_pkg::result_t result_reg;
    tse_pkg::result_t result_next;
    logic [63:0]      last_output_reg;
    logic [63:0]      last_output_next;
    logic [63:0]      last_output_inc;

    assign cfg.wrap_mask     = wrap_mask_reg;
    assign cfg.wrap_step     = wrap_step_reg;
    assign cfg.sanity_window = sanity_window_reg;

    // valid/stall chain
    always_comb
    begin
        ready[8] = !result_valid_reg || !result_stall;
        for (int k = 7; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k + 1];
        end
    end

    assign sample_stall = !ready[0];
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign track_fire   = valid_reg[0] && ready[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= sample_valid;
            end
            for (int k = 1; k < 8; k++)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
            if (ready[8])
            begin
                result_valid_reg <= valid_reg[7];
            end
        end
    end

    // configuration registers; a clear transaction also zeroes the offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_mask_reg     <= tse_pkg::WRAP_MASK_RST;
            wrap_step_reg     <= tse_pkg::WRAP_STEP_RST;
            sync_offset_reg   <= '0;
            drift_neg_reg     <= 1'b0;
            drift_mag_reg     <= '0;
            sanity_window_reg <= tse_pkg::SANITY_WINDOW_RST;
        end
        else if (track_fire && s0_reg.op == tse_pkg::OP_CLEAR)
        begin
            sync_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tse_pkg::REG_WRAP_MASK:     wrap_mask_reg   <= cfg_data;
                tse_pkg::REG_WRAP_STEP:     wrap_step_reg   <= cfg_data[62:0];
                tse_pkg::REG_SYNC_OFFSET:   sync_offset_reg <= cfg_data;
                tse_pkg::REG_DRIFT_FACTOR:
                begin
                    drift_neg_reg <= cfg_data[47];
                    drift_mag_reg <= cfg_data[47] ? (48'd0 - cfg_data[47:0]) : cfg_data[47:0];
                end
                tse_pkg::REG_SANITY_WINDOW: sanity_window_reg <= cfg_data[31:0];
                default:
                begin
                    wrap_mask_reg <= wrap_mask_reg;
                end
            endcase
        end
    end

    // input register
    always_comb
    begin
        s0_next.op      = sample.op;
        s0_next.low     = sample.raw_time & wrap_mask_reg;
        s0_next.dev_gap = sample.device_time - (sample.raw_time & wrap_mask_reg)
                          - {1'b0, wrap_step_reg};
        s0_next.dev_ok  = sample.device_time_ok;
    end

    tse_tracker u_tracker
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (track_fire),
        .item   (s0_reg),
        .cfg    (cfg),
        .result (track_out)
    );

    // offset, magnitude and partial products
    always_comb
    begin
        p2_next = p1_reg;
        if (p1_reg.op == tse_pkg::OP_EVENT)
        begin
            p2_next.value = p1_reg.value + o1_reg;
        end
        mag3_next = p2_reg.value[63] ? (64'd0 - p2_reg.value) : p2_reg.value;
        pp00_next = mag3_reg[31:0] * drift_mag_reg[31:0];
        pp01_next = mag3_reg[31:0] * drift_mag_reg[47:32];
        pp10_next = mag3_reg[63:32] * drift_mag_reg[31:0];
        pp11_next = mag3_reg[63:32] * drift_mag_reg[47:32];
        sum6      = low5_reg[103:0] + {7'd0, mid5_reg, 32'd0};
    end

    // drift applied and monotonic clamp
    always_comb
    begin
        p7_next = p6_reg;
        if (p6_reg.op == tse_pkg::OP_EVENT)
        begin
            p7_next.value = neg6_reg ? (p6_reg.value + m6_reg) : (p6_reg.value - m6_reg);
        end

        last_output_inc                 = last_output_reg + 64'd1;
        last_output_next                = last_output_reg;
        result_next.time_out            = p7_reg.value;
        result_next.wrapped             = p7_reg.wrapped;
        result_next.forced_forward      = p7_reg.forced_forward;
        result_next.clamped             = 1'b0;
        result_next.device_time_missing = p7_reg.device_time_missing;
        unique case (p7_reg.op)
            tse_pkg::OP_EVENT:
            begin
                if ($signed(p7_reg.value) < $signed(last_output_reg))
                begin
                    last_output_next     = last_output_inc;
                    result_next.time_out = last_output_inc;
                    result_next.clamped  = 1'b1;
                end
                else
                begin
                    last_output_next = p7_reg.value;
                end
            end
            tse_pkg::OP_CLEAR:
            begin
                last_output_next = '0;
            end
            default:
            begin
                last_output_next = last_output_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_output_reg <= '0;
        end
        else if (ready[8] && valid_reg[7])
        begin
            last_output_reg <= last_output_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            s0_reg <= s0_next;
        end
        if (ready[1])
        begin
            p1_reg <= track_out;
            o1_reg <= sync_offset_reg;
        end
        if (ready[2])
        begin
            p2_reg <= p2_next;
        end
        if (ready[3])
        begin
            p3_reg   <= p2_reg;
            mag3_reg <= mag3_next;
            neg3_reg <= p2_reg.value[63] ^ drift_neg_reg;
        end
        if (ready[4])
        begin
            p4_reg   <= p3_reg;
            pp00_reg <= pp00_next;
            pp01_reg <= pp01_next;
            pp10_reg <= pp10_next;
            pp11_reg <= pp11_next;
            neg4_reg <= neg3_reg;
        end
        if (ready[5])
        begin
            p5_reg   <= p4_reg;
            low5_reg <= {pp11_reg, pp00_reg};
            mid5_reg <= {17'd0, pp01_reg} + {1'b0, pp10_reg};
            neg5_reg <= neg4_reg;
        end
        if (ready[6])
        begin
            p6_reg   <= p5_reg;
            m6_reg   <= sum6[103:40];
            neg6_reg <= neg5_reg;
        end
        if (ready[7])
        begin
            p7_reg <= p7_next;
        end
        if (ready[8])
        begin
            result_reg <= result_next;
        end
    end

endmodule

/* sv/tse_tracker.sv */
`timescale 1ns / 1ps
// wrap tracking for timer and event streams: high parts, last low values, sanity check
module tse_tracker
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  tse_pkg::stage0_t item,
    input  tse_pkg::cfg_t    cfg,
    output tse_pkg::pipe_t   result
);

    logic [63:0] last_timer_low_reg;
    logic [63:0] last_timer_low_next;
    logic [63:0] last_event_low_reg;
    logic [63:0] last_event_low_next;
    logic [63:0] timer_high_reg;
    logic [63:0] timer_high_next;
    logic [63:0] event_high_reg;
    logic [63:0] event_high_next;

    logic [63:0] step;
    logic [63:0] win;
    logic [63:0] win_neg;
    logic [63:0] timer_diff;
    logic [63:0] event_diff;
    logic        timer_wrap;
    logic        event_wrap;
    logic [63:0] gap;
    logic        too_far;
    logic [63:0] event_low_inc;

    assign step          = {1'b0, cfg.wrap_step};
    assign win           = {32'd0, cfg.sanity_window};
    assign win_neg       = 64'd0 - win;
    assign timer_diff    = item.low - last_timer_low_reg;
    assign event_diff    = item.low - last_event_low_reg;
    assign timer_wrap    = timer_diff[63];
    assign event_wrap    = event_diff[63];
    assign gap           = item.dev_gap - event_high_reg;
    assign too_far       = ($signed(gap) > $signed(win)) || ($signed(gap) < $signed(win_neg));
    assign event_low_inc = last_event_low_reg + 64'd1;

    always_comb
    begin
        last_timer_low_next = last_timer_low_reg;
        last_event_low_next = last_event_low_reg;
        timer_high_next     = timer_high_reg;
        event_high_next     = event_high_reg;
        result              = '0;
        result.op           = item.op;
        unique case (item.op)
            tse_pkg::OP_TIMER:
            begin
                last_timer_low_next = item.low;
                if (timer_wrap)
                begin
                    timer_high_next = timer_high_reg + step;
                    result.value    = item.low + timer_high_reg + step;
                    result.wrapped  = 1'b1;
                end
                else
                begin
                    result.value = item.low + timer_high_reg;
                end
            end
            tse_pkg::OP_EVENT:
            begin
                priority if (event_wrap && !item.dev_ok)
                begin
                    // high part skipped, state kept
                    result.value               = item.low;
                    result.device_time_missing = 1'b1;
                end
                else if (event_wrap && too_far)
                begin
                    last_event_low_next   = event_low_inc & cfg.wrap_mask;
                    result.value          = event_low_inc + event_high_reg;
                    result.forced_forward = 1'b1;
                end
                else if (event_wrap)
                begin
                    event_high_next     = event_high_reg + step;
                    last_event_low_next = item.low;
                    result.value        = item.low + event_high_reg + step;
                    result.wrapped      = 1'b1;
                end
                else
                begin
                    last_event_low_next = item.low;
                    result.value        = item.low + event_high_reg;
                end
            end
            tse_pkg::OP_TIMEOUT:
            begin
                if (timer_high_reg > event_high_reg)
                begin
                    event_high_next     = timer_high_reg;
                    last_event_low_next = last_timer_low_reg;
                end
            end
            tse_pkg::OP_CLEAR:
            begin
                last_timer_low_next = '0;
                last_event_low_next = '0;
                timer_high_next     = '0;
                event_high_next     = '0;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_timer_low_reg <= '0;
            last_event_low_reg <= '0;
            timer_high_reg     <= '0;
            event_high_reg     <= '0;
        end
        else if (fire)
        begin
            last_timer_low_reg <= last_timer_low_next;
            last_event_low_reg <= last_event_low_next;
            timer_high_reg     <= timer_high_next;
            event_high_reg     <= event_high_next;
        end
    end

endmodule
